@@ design/ple_pkg.sv @@
// Shared types and constants for the positional list engine.
package ple_pkg;

    // Field widths of the input and result words.
    localparam int OPC_W    = 3;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 16;
    localparam int STS_W    = 2;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 32;

    // Operation codes carried on the slave tuser.
    localparam logic [OPC_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OPC_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OPC_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OPC_W-1:0] OP_READ   = 3'd3;
    localparam logic [OPC_W-1:0] OP_DUMP   = 3'd4;

    // Status codes carried on the master tuser.
    localparam logic [STS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STS_W-1:0] ST_FULL  = 2'd2;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_RD,
        S_CAP,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_DUMP_RD,
        S_DUMP_EMIT,
        S_EMIT
    } state_t;

endpackage

@@ design/ple_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/ple_mod.sv @@
// Iterative remainder unit: one restoring step per cycle over the position bits.
module ple_mod #(
    parameter int CW = 7
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ple_pkg::POS_W-1:0] dividend,
    input  logic [CW-1:0]             divisor,
    output logic                      done,
    output logic [CW-1:0]             remainder
);

    import ple_pkg::*;

    localparam int SW = $clog2(POS_W);
    localparam logic [SW-1:0] STEP_LAST = SW'(POS_W - 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [SW-1:0]   step_reg, step_next;
    logic [POS_W-1:0] dvd_reg, dvd_next;
    logic [CW-1:0]   div_reg, div_next;
    logic [CW-1:0]   rem_reg, rem_next;
    logic [CW:0]     trial;

    // One shift-and-subtract step of the remainder.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[POS_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next  = {dvd_reg[POS_W-2:0], 1'b0};
            step_next = step_reg + SW'(1);
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = CW'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[CW-1:0];
            end
            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Operand and remainder registers.
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ design/positional_list_engine_unit.sv @@
// Top level of the positional list engine: sequencer, list memory and output register.
//
// Usage: one command word enters on the slave stream (tuser = opcode, tdata =
// value and position) and zero or more result words leave on the master stream
// (tdata = value, tuser = status, tlast = final result of the command).
// The list lives in a RAM in list order; insert and delete move the entries
// behind the selected position one at a time through the single RAM port pair.
// Work per command, with n entries and selected slot s:
//   append: no result.
//   error or full status: sent to the result register without touching the list.
//   read: the remainder unit dominates.
//   insert: n - s entry moves; delete: n - 1 - s entry moves.
//   dump: n results from the last entry to the first.
// s_axis_tready is high only while the sequencer is idle.
// Reset clears the entry count, so the list starts empty; the RAM is not cleared.
// When the receiver stalls, the result waits in the output register and the
// sequencer holds before loading the next result; nothing is lost.
module positional_list_engine_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [31:0] item_value, [47:32] position
    input  logic [ple_pkg::S_DATA_W-1:0] s_axis_tdata,
    // [2:0] opcode
    input  logic [ple_pkg::OPC_W-1:0]    s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [31:0] result_value
    output logic [ple_pkg::M_DATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [ple_pkg::STS_W-1:0]    m_axis_tuser,
    output logic                         m_axis_tlast
);

    import ple_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     slot_reg, slot_next;
    logic [OPC_W-1:0]  op_reg, op_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [STS_W-1:0]  status_reg, status_next;

    logic              out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]  out_data_reg;
    logic [STS_W-1:0]  out_status_reg;
    logic              out_last_reg;
    logic              out_free;
    logic              out_load;
    logic [VAL_W-1:0]  load_data;
    logic [STS_W-1:0]  load_status;
    logic              load_last;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [VAL_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [VAL_W-1:0]  ram_rdata;

    logic              mod_start;
    logic              mod_done;
    logic [CW-1:0]     mod_rem;

    logic [CW-1:0]     idx_inc;
    logic [CW-1:0]     idx_dec;
    logic [CW-1:0]     slot_calc;
    logic [OPC_W-1:0]  in_op;

    // List storage.
    ple_ram #(
        .WIDTH(VAL_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared remainder unit for position reduction.
    ple_mod #(
        .CW(CW)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (s_axis_tdata[VAL_W +: POS_W]),
        .divisor   (count_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign idx_inc   = idx_reg + CNT_ONE;
    assign idx_dec   = idx_reg - CNT_ONE;
    assign slot_calc = (mod_rem == '0) ? (count_reg - CNT_ONE) : (mod_rem - CNT_ONE);
    assign in_op     = s_axis_tuser;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    // Sequencer: next state, memory control and result loading.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        slot_next   = slot_reg;
        op_next     = op_reg;
        val_next    = val_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = val_reg;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        mod_start   = 1'b0;
        out_load    = 1'b0;
        load_data   = val_reg;
        load_status = status_reg;
        load_last   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next  = in_op;
                    val_next = s_axis_tdata[VAL_W-1:0];
                    if ((in_op > OP_DUMP) || (in_op != OP_APPEND && count_reg == '0))
                    begin
                        val_next    = '0;
                        status_next = ST_EMPTY;
                        state_next  = S_EMIT;
                    end
                    else if ((in_op == OP_APPEND || in_op == OP_INSERT) &&
                             count_reg == CAP_CNT)
                    begin
                        val_next    = '0;
                        status_next = ST_FULL;
                        state_next  = S_EMIT;
                    end
                    else if (in_op == OP_APPEND)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[AW-1:0];
                        ram_wdata  = s_axis_tdata[VAL_W-1:0];
                        count_next = count_reg + CNT_ONE;
                    end
                    else if (in_op == OP_DUMP)
                    begin
                        idx_next   = count_reg;
                        state_next = S_DUMP_RD;
                    end
                    else
                    begin
                        mod_start  = 1'b1;
                        state_next = S_MOD;
                    end
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    slot_next = slot_calc;
                    if (op_reg == OP_INSERT)
                    begin
                        idx_next   = count_reg;
                        state_next = S_INS_RD;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = slot_reg[AW-1:0];
                state_next = S_CAP;
            end
            S_CAP:
            begin
                val_next    = ram_rdata;
                status_next = ST_OK;
                if (op_reg == OP_DELETE)
                begin
                    idx_next   = slot_reg;
                    state_next = S_DEL_RD;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            // Insert: move entries back from the end down to the slot, then write.
            S_INS_RD:
            begin
                if (idx_reg == slot_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = slot_reg[AW-1:0];
                    ram_wdata  = val_reg;
                    count_next = count_reg + CNT_ONE;
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_dec[AW-1:0];
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[AW-1:0];
                ram_wdata  = ram_rdata;
                idx_next   = idx_dec;
                state_next = S_INS_RD;
            end
            // Delete: move entries forward from behind the slot to the end.
            S_DEL_RD:
            begin
                if (idx_inc < count_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_inc[AW-1:0];
                    state_next = S_DEL_WR;
                end
                else
                begin
                    count_next = count_reg - CNT_ONE;
                    state_next = S_EMIT;
                end
            end
            S_DEL_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[AW-1:0];
                ram_wdata  = ram_rdata;
                idx_next   = idx_inc;
                state_next = S_DEL_RD;
            end
            // Dump: read from the last entry toward the first.
            S_DUMP_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = idx_dec[AW-1:0];
                state_next = S_DUMP_EMIT;
            end
            S_DUMP_EMIT:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    load_data   = ram_rdata;
                    load_status = ST_OK;
                    load_last   = (idx_reg == CNT_ONE);
                    idx_next    = idx_dec;
                    state_next  = (idx_reg == CNT_ONE) ? S_IDLE : S_DUMP_RD;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output word valid flag.
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            op_reg        <= OP_APPEND;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        if (out_load)
        begin
            out_data_reg   <= load_data;
            out_status_reg <= load_status;
            out_last_reg   <= load_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    // The entry count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    // The count moves by at most one per cycle.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg) ||
                  count_reg == CW'($past(count_reg) + CNT_ONE) ||
                  count_reg == CW'($past(count_reg) - CNT_ONE)))
        else $error("entry count jumped");

    // The remainder unit only finishes while the sequencer waits for it.
    a_mod_done: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> state_reg == S_MOD)
        else $error("remainder done outside wait state");

    // The memory is never read and written in the same cycle.
    a_ram_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("memory read and write collide");

endmodule
